// ===== rtl/core/rnpb_pkg.sv =====
`default_nettype none
package rnpb_pkg;

	// Field count width covers the whole supported range of the field limit (up to 63).
	localparam int unsigned JOB_CNT_W = 6;

	// Upper half of the header word: V=2, P=0, FMT=1, then PT=205.
	localparam logic [15:0] HDR_TOP = 16'h81CD;

	// Header (12 bytes) plus one field: the smallest packet worth building.
	localparam logic [16:0] MIN_PKT_BYTES = 17'd16;

	// A field covers the PID plus the 16 numbers after it.
	localparam logic [15:0] BLP_SPAN = 16'd16;

	typedef enum logic {
		CFG_SENDER_SSRC   = 1'b0,
		CFG_CAPACITY      = 1'b1
	} cfg_index_t;

	// One finished list, handed from the front to the back.
	typedef struct packed {
		logic [JOB_CNT_W-1:0] count;
		logic                 empty;
	} job_t;

endpackage
`default_nettype wire

// ===== rtl/core/rnpb_ram.sv =====
`default_nettype none
module rnpb_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                            wr_data,
	input  wire logic                                        rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/rnpb_front.sv =====
`default_nettype none
module rnpb_front
	import rnpb_pkg::*;
#(
	parameter int unsigned MAX_FIELDS = 16,
	localparam int unsigned ADDR_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [15:0]       seq_number,
	input  wire logic              list_end,
	input  wire logic [15:0]       capacity,
	output logic                   ram_we,
	output logic      [ADDR_W-1:0] ram_addr,
	output logic      [31:0]       ram_data,
	output logic                   push,
	output job_t                   job
);

	logic [JOB_CNT_W-1:0] total_q, total_n;
	logic [15:0]          pid_q, pid_n;
	logic [15:0]          blp_q, blp_n;
	logic                 stop_q, stop_n;
	logic [15:0]          diff;
	logic [3:0]           bit_pos;
	logic [16:0]          need_bytes;

	always_comb begin
		total_n    = total_q;
		pid_n      = pid_q;
		blp_n      = blp_q;
		stop_n     = stop_q;
		diff       = seq_number - pid_q;
		bit_pos    = 4'(diff - 16'd1);
		need_bytes = MIN_PKT_BYTES + (17'(total_q) << 2);
		if (!stop_q) begin
			// Plain unsigned compare: a wrap back to zero opens a new field.
			if (total_q != '0 && seq_number > pid_q && diff <= BLP_SPAN) begin
				blp_n = blp_q | (16'd1 << bit_pos);
			end else if (total_q >= JOB_CNT_W'(MAX_FIELDS) ||
				need_bytes > {1'b0, capacity}) begin
				stop_n = 1'b1;
			end else begin
				pid_n   = seq_number;
				blp_n   = '0;
				total_n = total_q + 1'b1;
			end
		end
	end

	// The open field is rewritten on every word, so the store always holds its latest mask.
	assign ram_we    = take && (total_n != '0);
	assign ram_addr  = ADDR_W'(total_n - 1'b1);
	assign ram_data  = {pid_n, blp_n};
	assign push      = take && list_end;
	assign job.count = total_n;
	assign job.empty = (capacity < 16'(MIN_PKT_BYTES)) || (total_n == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			pid_q   <= '0;
			blp_q   <= '0;
			stop_q  <= 1'b0;
		end else if (take) begin
			if (list_end) begin
				total_q <= '0;
				pid_q   <= '0;
				blp_q   <= '0;
				stop_q  <= 1'b0;
			end else begin
				total_q <= total_n;
				pid_q   <= pid_n;
				blp_q   <= blp_n;
				stop_q  <= stop_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/rnpb_jobq.sv =====
`default_nettype none
module rnpb_jobq
	import rnpb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output logic      not_empty,
	output job_t      head
);

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/rnpb_back.sv =====
`default_nettype none
module rnpb_back
	import rnpb_pkg::*;
#(
	parameter int unsigned MAX_FIELDS = 16,
	localparam int unsigned ADDR_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              job_valid,
	input  wire job_t              job,
	output logic                   pop,
	input  wire logic [31:0]       ssrc,
	output logic                   rd_en,
	output logic      [ADDR_W-1:0] rd_addr,
	input  wire logic [31:0]       rd_data,
	output logic                   active,
	output logic                   strobe,
	output logic      [31:0]       packet_word,
	output logic                   word_last,
	output logic                   packet_empty
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SSRC_SENDER,
		ST_SSRC_MEDIA,
		ST_FIELD
	} state_t;

	state_t               state_q;
	logic [JOB_CNT_W-1:0] count_q;
	logic [JOB_CNT_W-1:0] idx_q;
	logic [JOB_CNT_W-1:0] idx_next;

	assign idx_next = idx_q + 1'b1;
	assign pop      = (state_q == ST_IDLE) && job_valid;
	assign active   = (state_q != ST_IDLE);

	// Reads run one word ahead of the output register.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ADDR_W'(idx_next);
		case (state_q)
			ST_SSRC_MEDIA: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			ST_FIELD: begin
				rd_en = (idx_next < count_q);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			strobe       <= 1'b0;
			packet_word  <= '0;
			word_last    <= 1'b0;
			packet_empty <= 1'b0;
		end else begin
			strobe       <= 1'b0;
			word_last    <= 1'b0;
			packet_empty <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						strobe <= 1'b1;
						if (job.empty) begin
							packet_word  <= '0;
							word_last    <= 1'b1;
							packet_empty <= 1'b1;
						end else begin
							packet_word <= {HDR_TOP, 16'(job.count) + 16'd2};
							count_q     <= job.count;
							state_q     <= ST_SSRC_SENDER;
						end
					end
				end
				ST_SSRC_SENDER: begin
					strobe      <= 1'b1;
					packet_word <= ssrc;
					state_q     <= ST_SSRC_MEDIA;
				end
				ST_SSRC_MEDIA: begin
					strobe      <= 1'b1;
					packet_word <= ssrc;
					idx_q       <= '0;
					state_q     <= ST_FIELD;
				end
				ST_FIELD: begin
					strobe      <= 1'b1;
					packet_word <= rd_data;
					idx_q       <= idx_next;
					if (idx_next == count_q) begin
						word_last <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/rtcp_nack_packet_builder.sv =====
// Output: a list end pushes a job into the queue, and the back end registers the first
// packet word when it pops that job; all N+3 words (header, SSRC twice, N fields) follow
// back to back, one per cycle. An empty result is a single word.
// Throughput: one sequence number per cycle while busy is low, until list end; busy then
// stays high while the job is queued and the back end reads the store, one entry per cycle.
// Reset: arst_n clears list state, the queue, the sequencer and the output strobe at once.
`default_nettype none
module rtcp_nack_packet_builder
	import rnpb_pkg::*;
#(
	parameter int unsigned MAX_FIELDS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] seq_number,
	input  wire logic        list_end,
	output logic             strobe,
	output logic      [31:0] packet_word,
	output logic             word_last,
	output logic             packet_empty,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int unsigned ADDR_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

	// Configuration registers: the user must change them only while idle; no guard here.
	logic [31:0] ssrc_q;
	logic [15:0] capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ssrc_q     <= '0;
			capacity_q <= 16'd1200;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_SENDER_SSRC: ssrc_q     <= cfg_data;
				CFG_CAPACITY:    capacity_q <= cfg_data[15:0];
				default:         ssrc_q     <= ssrc_q;
			endcase
		end
	end

	// A word is taken whenever start is high and busy is low.
	logic take;
	assign take = start && !busy;

	// Front end: folds each sequence number into the open field and writes it to the store.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_wr_addr;
	logic [31:0]       ram_wr_data;
	logic              push;
	job_t              push_job;

	rnpb_front #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.seq_number (seq_number),
		.list_end   (list_end),
		.capacity   (capacity_q),
		.ram_we     (ram_we),
		.ram_addr   (ram_wr_addr),
		.ram_data   (ram_wr_data),
		.push       (push),
		.job        (push_job)
	);

	// Field store: PID in the upper half, lost-packet mask in the lower half.
	logic              ram_rd_en;
	logic [ADDR_W-1:0] ram_rd_addr;
	logic [31:0]       ram_rd_data;

	rnpb_ram #(
		.WIDTH(32),
		.DEPTH(MAX_FIELDS)
	) u_field_store (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Finished lists wait here until the back end is free.
	logic job_valid;
	logic pop;
	job_t head_job;

	rnpb_jobq u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.not_empty (job_valid),
		.head      (head_job)
	);

	// Back end: streams header, both SSRC words and the stored fields.
	logic back_active;

	rnpb_back #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (head_job),
		.pop          (pop),
		.ssrc         (ssrc_q),
		.rd_en        (ram_rd_en),
		.rd_addr      (ram_rd_addr),
		.rd_data      (ram_rd_data),
		.active       (back_active),
		.strobe       (strobe),
		.packet_word  (packet_word),
		.word_last    (word_last),
		.packet_empty (packet_empty)
	);

	// The front end holds off while a packet is queued or being read out, since a new
	// list would overwrite store entries that are still to be sent.
	assign busy = job_valid || back_active;

	// A list end always leaves a job for the back end.
	a_end_makes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take && list_end |=> busy)
		else $error("list end did not raise busy");

	// The empty result is a single zero word that closes the packet.
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && packet_empty |-> word_last && (packet_word == '0))
		else $error("malformed empty result");

	// Packet words come without gaps until the last one.
	a_no_gaps: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !word_last |=> strobe)
		else $error("gap inside a packet");

	// The store is never written while a packet is being read from it.
	a_no_store_clash: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !back_active && !job_valid)
		else $error("field store written during readout");

endmodule
`default_nettype wire

// ===== tb/rtcp_nack_packet_builder_checker.sv =====
`timescale 1ns / 1ps
module rtcp_nack_packet_builder_checker
	import rnpb_pkg::*;
#(
	parameter int unsigned MAX_FIELDS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [15:0] seq_number,
	input  wire logic        list_end,
	input  wire logic        strobe,
	input  wire logic [31:0] packet_word,
	input  wire logic        word_last,
	input  wire logic        packet_empty,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               words_due,
	output int               fail_count
);

	localparam int HDR_BYTES = 12;

	typedef struct packed {
		logic [31:0] word;
		logic        is_last;
		logic        is_empty;
	} nack_word_t;

	nack_word_t  expected_words[$];
	logic [31:0] ssrc_reg     = '0;
	logic [15:0] capacity_reg = 16'd1200;
	logic [31:0] nack_fields[MAX_FIELDS];
	int          open_fields  = 0;
	logic [15:0] pid_reg      = '0;
	bit          halted       = 1'b0;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	task automatic restart_list();
		open_fields = 0;
		pid_reg     = '0;
		halted      = 1'b0;
	endtask

	// Folds one missing number into the open field or opens a new one.
	task automatic absorb_number(input logic [15:0] seq);
		logic [15:0] offset;
		if (halted) return;
		offset = seq - pid_reg;
		if (open_fields > 0 && seq > pid_reg && offset >= 16'd1 && offset <= BLP_SPAN) begin
			nack_fields[open_fields - 1][offset - 16'd1] = 1'b1;
			return;
		end
		if (open_fields >= int'(MAX_FIELDS) ||
				HDR_BYTES + 4 * (open_fields + 1) > int'(capacity_reg)) begin
			halted = 1'b1;
			return;
		end
		nack_fields[open_fields] = {seq, 16'h0000};
		pid_reg = seq;
		open_fields++;
	endtask

	task automatic queue_packet();
		if (capacity_reg < MIN_PKT_BYTES[15:0] || open_fields == 0) begin
			expected_words.push_back('{word: '0, is_last: 1'b1, is_empty: 1'b1});
		end else begin
			expected_words.push_back('{word: {HDR_TOP, 16'(open_fields + 2)},
				is_last: 1'b0, is_empty: 1'b0});
			expected_words.push_back('{word: ssrc_reg, is_last: 1'b0, is_empty: 1'b0});
			expected_words.push_back('{word: ssrc_reg, is_last: 1'b0, is_empty: 1'b0});
			for (int i = 0; i < open_fields; i++) begin
				expected_words.push_back('{word: nack_fields[i],
					is_last: (i + 1 == open_fields), is_empty: 1'b0});
			end
		end
		restart_list();
	endtask

	always @(posedge clk or negedge arst_n) begin
		nack_word_t due;
		if (!arst_n) begin
			expected_words.delete();
			ssrc_reg     = '0;
			capacity_reg = 16'd1200;
			foreach (nack_fields[i]) nack_fields[i] = '0;
			restart_list();
		end else begin
			// Outputs are compared before this edge's input is predicted, so a
			// stray strobe can never pair with a word taken at the same edge.
			if (strobe) begin
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected output word %08h", packet_word));
				end else begin
					due = expected_words.pop_front();
					if (packet_word !== due.word)
						report_mismatch($sformatf("packet_word %08h, wanted %08h",
							packet_word, due.word));
					if (word_last !== due.is_last)
						report_mismatch($sformatf("word_last %b, wanted %b",
							word_last, due.is_last));
					if (packet_empty !== due.is_empty)
						report_mismatch($sformatf("packet_empty %b, wanted %b",
							packet_empty, due.is_empty));
				end
			end
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_SENDER_SSRC: ssrc_reg = cfg_data;
					CFG_CAPACITY:    capacity_reg = cfg_data[15:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				absorb_number(seq_number);
				if (list_end) queue_packet();
			end
		end
		words_due = expected_words.size();
	end

endmodule

// ===== tb/rtcp_nack_packet_builder_tb.sv =====
`timescale 1ns / 1ps
module rtcp_nack_packet_builder_tb;
	import rnpb_pkg::*;

	localparam int unsigned MAX_FIELDS = 16;
	// Longest legal quiet stretch is a sender gap plus a full packet readout plus
	// the settle waits; this limit leaves wide margin.
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_WORDS = 360;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [15:0] seq_number = '0;
	logic        list_end = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        busy;
	logic        strobe;
	logic [31:0] packet_word;
	logic        word_last;
	logic        packet_empty;
	int          words_due;
	int          fail_count;

	// When set, the sender offers its words back to back for a whole list.
	bit          eager = 1'b0;
	int          words_sent = 0;

	always #4 clk = ~clk;

	rtcp_nack_packet_builder #(
		.MAX_FIELDS(MAX_FIELDS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.seq_number  (seq_number),
		.list_end    (list_end),
		.strobe      (strobe),
		.packet_word (packet_word),
		.word_last   (word_last),
		.packet_empty(packet_empty),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	rtcp_nack_packet_builder_checker #(
		.MAX_FIELDS(MAX_FIELDS)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.seq_number  (seq_number),
		.list_end    (list_end),
		.strobe      (strobe),
		.packet_word (packet_word),
		.word_last   (word_last),
		.packet_empty(packet_empty),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.words_due   (words_due),
		.fail_count  (fail_count)
	);

	// All driving tasks are entered and left on a falling edge, so every input
	// changes half a period away from the edge that samples it.

	// One register write, held for exactly one rising edge.
	task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Holds the sender off until every predicted output word has come out, then
	// waits on so that a word taken last has surely been absorbed before any
	// register changes under it.
	task automatic settle();
		start = 1'b0;
		while (words_due != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic int draw_gap();
		return eager ? 0 : $urandom_range(0, 13);
	endfunction

	// Offers one word after the given gap and waits until the block takes it.
	// With no gap the start line simply stays high for the next word.
	task automatic send_number(input logic [15:0] seq, input logic fin, input int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		seq_number = seq;
		list_end = fin;
		do @(posedge clk); while (busy);
		@(negedge clk);
		words_sent++;
	endtask

	// Capacities are weighted toward values that allow a full packet, with the
	// small-capacity edges (no field, exactly one field) still drawn often.
	function automatic logic [31:0] pick_capacity();
		logic [15:0] cap;
		case ($urandom_range(0, 9))
			0: cap = 16'd0;
			1: cap = 16'd15;
			2: cap = 16'd16;
			3: cap = 16'($urandom_range(17, 75));
			4: cap = 16'd76;
			5: cap = 16'hFFFF;
			6: cap = 16'd1200;
			default: cap = 16'($urandom_range(76, 65535));
		endcase
		// The upper half of the data bus is not part of this register.
		return {16'($urandom), cap};
	endfunction

	function automatic logic [31:0] pick_ssrc();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Picks the next missing number of a well-formed list: mostly small forward
	// steps that land in the open field's mask, with steps just past the mask,
	// repeats, backward steps and wild jumps mixed in.
	function automatic logic [15:0] next_number(input logic [15:0] prev, input bit wide);
		int r;
		r = wide ? 6 : $urandom_range(0, 9);
		case (r)
			0, 1, 2, 3, 4, 5: return prev + 16'($urandom_range(1, 16));
			6: return prev + 16'($urandom_range(17, 40));
			7: return prev;
			8: return 16'($urandom);
			default: return prev - 16'($urandom_range(1, 20));
		endcase
	endfunction

	task automatic send_random_list();
		int kind;
		int len;
		logic [15:0] seq;
		kind = $urandom_range(0, 9);
		eager = ($urandom_range(0, 3) == 0);
		if (kind == 0) begin
			// Noise: numbers with no relation to each other.
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++)
				send_number(16'($urandom), i == len - 1, draw_gap());
		end else begin
			// Wide lists keep jumping so the field limit is reached.
			len = (kind <= 2) ? $urandom_range(16, 22) : $urandom_range(1, 30);
			seq = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(65500, 65535))
				: 16'($urandom);
			for (int i = 0; i < len; i++) begin
				send_number(seq, i == len - 1, draw_gap());
				seq = next_number(seq, kind <= 2);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed part.
		write_reg(CFG_SENDER_SSRC, 32'hFFFF_FFFF);
		write_reg(CFG_CAPACITY, 32'd1200);

		// Mask offsets of one and sixteen, one past the mask, a repeated number,
		// a backward step, the top number and the wrap to zero.
		send_number(16'd100, 1'b0, 0);
		send_number(16'd101, 1'b0, 0);
		send_number(16'd116, 1'b0, 3);
		send_number(16'd117, 1'b0, 0);
		send_number(16'd117, 1'b0, 1);
		send_number(16'd50, 1'b0, 0);
		send_number(16'hFFFF, 1'b0, 0);
		send_number(16'h0000, 1'b1, 0);

		// A list of a single number.
		send_number(16'h5A5A, 1'b1, 2);

		// Capacity below one field gives the empty result.
		settle();
		write_reg(CFG_SENDER_SSRC, 32'h0000_0000);
		write_reg(CFG_CAPACITY, 32'd15);
		send_number(16'd7, 1'b0, 0);
		send_number(16'd8, 1'b1, 0);

		// Room for exactly one field: the second field stops the packing.
		settle();
		write_reg(CFG_CAPACITY, 32'd16);
		send_number(16'd1, 1'b0, 0);
		send_number(16'd300, 1'b1, 0);

		// Capacity raised during a list that could open no field: still empty.
		settle();
		write_reg(CFG_CAPACITY, 32'd8);
		send_number(16'd9, 1'b0, 0);
		settle();
		write_reg(CFG_CAPACITY, 32'd1200);
		send_number(16'd10, 1'b1, 0);

		// Capacity lowered during a list that has open fields: empty as well.
		settle();
		write_reg(CFG_SENDER_SSRC, 32'h1234_5678);
		send_number(16'd20, 1'b0, 0);
		send_number(16'd40, 1'b0, 0);
		settle();
		write_reg(CFG_CAPACITY, 32'd0);
		send_number(16'd60, 1'b1, 0);

		settle();
		write_reg(CFG_CAPACITY, 32'hFFFF);

		// Random part, in phases separated by register changes.
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			if ($urandom_range(0, 3) == 0) begin
				settle();
				if ($urandom_range(0, 2) != 0) write_reg(CFG_CAPACITY, pick_capacity());
				if ($urandom_range(0, 1) == 0) write_reg(CFG_SENDER_SSRC, pick_ssrc());
			end else if ($urandom_range(0, 7) == 0) begin
				// Let the output side drain completely before the next list.
				settle();
			end
			send_random_list();
		end

		start = 1'b0;
		while (words_due != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog: ends the run if neither side moves a word for too long.
	initial begin : watchdog
		int quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || strobe || cfg_we) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("status: fail");
		$finish;
	end

endmodule
